### rtl/cfsr_pkg.sv
// Types and constants shared by the CAN frame subscriber router.
// Depends on nothing; the router top level and its port list import it.
package cfsr_pkg;

    localparam int ID_W = 29;

    typedef enum logic [2:0] {
        CMD_ROUTE  = 3'd0,
        CMD_OPEN   = 3'd1,
        CMD_CLOSE  = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_COUNT  = 3'd4,
        CMD_ATTACH = 3'd5,
        CMD_DETACH = 3'd6
    } cmd_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_INVALID   = 2'd2;

    localparam logic [1:0] MODE_STD = 2'd0;
    localparam logic [1:0] MODE_EXT = 2'd1;

    typedef struct packed {
        logic [2:0]      cmd;
        logic [2:0]      client;
        logic [7:0]      channel;
        logic [ID_W-1:0] frame_id;
        logic            frame_ext;
        logic [5:0]      filter_slot;
        logic [ID_W-1:0] filter_id;
        logic [ID_W-1:0] filter_mask;
        logic [1:0]      filter_ext_mode;
        logic [7:0]      new_count;
        logic            link_ready;
    } in_t;

    typedef struct packed {
        logic [7:0] dest_mask;
        logic [1:0] status;
    } out_t;

    // One acceptance filter as it is held in the filter memory.
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] mask;
        logic [1:0]      mode;
    } filt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

### rtl/cfsr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; used for the per-slot filter tables of the router.
module cfsr_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

### rtl/can_frame_subscriber_router_top.sv
// CAN frame subscriber router: top level with command decode, slot state and filter scan.
// Depends on cfsr_pkg and cfsr_ram (one filter memory per subscriber slot).

// The block takes one command at a time. Attach, detach, open, close, count and
// filter writes pass from acceptance through the execute and done states to the
// result. A route command scans the filter memories: every slot has its own memory,
// and one filter index is read per cycle for all slots together, through the scan
// and drain states, as each filter memory has a single read port. A route on an
// invalid channel goes from execute straight to done. After each result has been
// loaded into the output register the block is ready again in the cycle after,
// while that result may still wait for m_ready. Filter entries that were never
// written are undefined; a filter count must only cover written entries.
module can_frame_subscriber_router_top #(
    parameter int NUM_SLOTS        = 8,
    parameter int FILTERS_PER_SLOT = 64,
    parameter int NUM_CHAN         = 4,
    parameter int VIRTUAL_CHAN     = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cfsr_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output cfsr_pkg::out_t m_data
);

    import cfsr_pkg::*;

    localparam int SW   = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
    localparam int AW   = FILTERS_PER_SLOT > 1 ? $clog2(FILTERS_PER_SLOT) : 1;
    localparam int CNTW = $clog2(FILTERS_PER_SLOT + 1);
    localparam int CHW  = NUM_CHAN > 1 ? $clog2(NUM_CHAN) : 1;
    localparam int FW   = $bits(filt_t);

    localparam logic [8:0]    FILT_MAX   = 9'(FILTERS_PER_SLOT);
    localparam logic [5:0]    SLOT_LIM   = 6'(NUM_SLOTS);
    localparam logic [7:0]    CHAN_LIM   = 8'(NUM_CHAN);
    localparam logic [7:0]    VIRT_LIM   = 8'(VIRTUAL_CHAN);
    localparam logic [AW-1:0] LAST_INDEX = AW'(FILTERS_PER_SLOT - 1);

    state_t state_reg, state_next;
    in_t    item_reg;

    logic [NUM_SLOTS-1:0] active_reg, active_next;
    logic [NUM_CHAN-1:0]  subs_reg  [NUM_SLOTS];
    logic [NUM_CHAN-1:0]  subs_next [NUM_SLOTS];
    logic [CNTW-1:0]      count_reg [NUM_SLOTS];
    logic [CNTW-1:0]      count_next[NUM_SLOTS];
    logic [NUM_SLOTS-1:0] hit_reg, hit_next;

    logic [AW-1:0] scan_idx_reg, scan_idx_next;
    logic [AW-1:0] cmp_idx_reg;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [1:0]    status_reg, status_next;

    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;

    logic          valid_ch;
    logic          virt_ch;
    logic          client_ok;
    logic          fslot_ok;
    logic [SW-1:0] slot_idx;
    logic [CHW-1:0] chan_idx;
    logic [AW-1:0] waddr;
    logic [8:0]    req_count;
    logic [CNTW-1:0] sat_count;
    logic          ram_we_any;
    filt_t         wr_filt;

    filt_t                rd_filt [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_we;
    logic [NUM_SLOTS-1:0] filt_hit;
    logic [NUM_SLOTS-1:0] dest_full;
    logic [7:0]           dest_vis;

    assign valid_ch  = item_reg.channel < CHAN_LIM;
    assign virt_ch   = item_reg.channel < VIRT_LIM;
    assign client_ok = 6'(item_reg.client) < SLOT_LIM;
    assign fslot_ok  = 9'(item_reg.filter_slot) < FILT_MAX;
    assign slot_idx  = SW'(item_reg.client);
    assign chan_idx  = CHW'(item_reg.channel);
    assign waddr     = AW'(item_reg.filter_slot);
    assign req_count = 9'(item_reg.new_count);
    assign sat_count = (req_count > FILT_MAX) ? FILT_MAX[CNTW-1:0] : req_count[CNTW-1:0];

    assign wr_filt.id   = item_reg.filter_id;
    assign wr_filt.mask = item_reg.filter_mask;
    assign wr_filt.mode = item_reg.filter_ext_mode;

    // Filter writes happen only in the execute cycle and read data is used only while
    // scanning, so a read and a write never meet on the same entry.
    assign ram_we_any = (state_reg == ST_EXEC) && (item_reg.cmd == CMD_WRITE)
                        && client_ok && fslot_ok;

    genvar gs;
    generate
        for (gs = 0; gs < NUM_SLOTS; gs++) begin : g_slot
            logic [FW-1:0] rd_raw;
            logic          mode_ok;
            logic          id_ok;
            logic          in_range;

            assign slot_we[gs] = ram_we_any && (slot_idx == SW'(gs));

            cfsr_ram #(
                .WIDTH (FW),
                .DEPTH (FILTERS_PER_SLOT)
            ) u_filt_ram (
                .clk   (aclk),
                .we    (slot_we[gs]),
                .waddr (waddr),
                .wdata (wr_filt),
                .raddr (scan_idx_reg),
                .rdata (rd_raw)
            );

            assign rd_filt[gs] = filt_t'(rd_raw);

            assign mode_ok  = !((rd_filt[gs].mode == MODE_EXT) && !item_reg.frame_ext)
                              && !((rd_filt[gs].mode == MODE_STD) && item_reg.frame_ext);
            assign id_ok    = ((item_reg.frame_id ^ rd_filt[gs].id) & rd_filt[gs].mask) == '0;
            assign in_range = CNTW'(cmp_idx_reg) < count_reg[gs];
            assign filt_hit[gs] = cmp_valid_reg && in_range && mode_ok && id_ok;

            // A slot with no filters accepts every frame.
            assign dest_full[gs] = active_reg[gs] && subs_reg[gs][chan_idx]
                                   && ((count_reg[gs] == '0) || hit_reg[gs]);
        end

        for (gs = 0; gs < 8; gs++) begin : g_dest
            if (gs < NUM_SLOTS) begin : g_vis
                assign dest_vis[gs] = dest_full[gs];
            end else begin : g_none
                assign dest_vis[gs] = 1'b0;
            end
        end
    endgenerate

    always_comb begin
        state_next     = state_reg;
        active_next    = active_reg;
        subs_next      = subs_reg;
        count_next     = count_reg;
        hit_next       = hit_reg | filt_hit;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        s_ready        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                hit_next      = '0;
                scan_idx_next = '0;
                status_next   = STATUS_OK;
                state_next    = ST_DONE;
                case (item_reg.cmd)
                    CMD_ROUTE: begin
                        if (!valid_ch) begin
                            status_next = STATUS_INVALID;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                    CMD_OPEN: begin
                        if (!(valid_ch && (virt_ch || item_reg.link_ready))) begin
                            status_next = STATUS_NOT_FOUND;
                        end else if (client_ok) begin
                            subs_next[slot_idx][chan_idx] = 1'b1;
                        end
                    end
                    CMD_CLOSE: begin
                        if (!valid_ch) begin
                            status_next = STATUS_INVALID;
                        end else if (client_ok) begin
                            subs_next[slot_idx][chan_idx] = 1'b0;
                        end
                    end
                    CMD_COUNT: begin
                        if (client_ok) begin
                            count_next[slot_idx] = sat_count;
                        end
                    end
                    CMD_ATTACH: begin
                        if (client_ok) begin
                            active_next[slot_idx] = 1'b1;
                            subs_next[slot_idx]   = '0;
                            count_next[slot_idx]  = '0;
                        end
                    end
                    CMD_DETACH: begin
                        if (client_ok) begin
                            active_next[slot_idx] = 1'b0;
                        end
                    end
                    default: begin
                        // Filter writes go straight to the memories; the unused code does nothing.
                    end
                endcase
            end
            ST_SCAN: begin
                cmp_valid_next = 1'b1;
                if (scan_idx_reg == LAST_INDEX) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                // The last filter entry is compared in this cycle.
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.status    = status_reg;
                    m_data_next.dest_mask = ((item_reg.cmd == CMD_ROUTE) && valid_ch)
                                            ? dest_vis : 8'd0;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                subs_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
            subs_reg      <= subs_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        hit_reg      <= hit_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= scan_idx_reg;
        status_reg   <= status_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
